// File: sv/bbl_pkg.sv
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared types and constants for the 5x5 box blur stream.
// ----------------------------------------------------------------------------
package bbl_pkg;

    // pixel and window geometry
    localparam int PIX_W             = 8;
    localparam int WIN               = 5;
    localparam int LINES             = WIN - 1;
    localparam int EDGE              = WIN - 1;
    localparam int DEFAULT_MAX_WIDTH = 2048;

    // configuration registers
    localparam int WIDTH_W      = 12;
    localparam int HEIGHT_W     = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int ROW_W        = 12;
    localparam int MAX_HEIGHT   = 4096;
    localparam int WIDTH_RESET  = 512;
    localparam int HEIGHT_RESET = 512;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // arithmetic: column sum, window sum, divide by 25 as multiply and shift
    localparam int CSUM_W      = 11;
    localparam int TOTAL_W     = 13;
    localparam int RECIP       = 5243;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = 25;

    // one column record: four line buffer pixels, the new pixel and its class
    typedef struct packed {
        logic [LINES*PIX_W-1:0] lines;
        logic [PIX_W-1:0]       pixel;
        logic                   emit;
        logic                   last;
    } col_rec_t;

endpackage

// File: sv/bbl_front.sv
// ----------------------------------------------------------------------------
// bbl_front
// Accepts pixels, tracks row and column, reads and rotates the line buffers
// and classifies each pixel as producing a result or not.
// ----------------------------------------------------------------------------
module bbl_front #(
    parameter int MAX_WIDTH = bbl_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  bbl_pkg::cfg_index_t             cfg_index,
    input  logic [bbl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bbl_pkg::PIX_W-1:0]       s_pixel,
    output logic                            q_push,
    input  logic                            q_full,
    output bbl_pkg::col_rec_t               q_data
);
    import bbl_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
    localparam int LW = LINES * PIX_W;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]       col_reg;
    logic [ROW_W-1:0]    row_reg;

    logic [EW-1:0]       w_ext;
    logic [CW:0]         eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic [CW:0]         col_inc;
    logic [ROW_W:0]      row_inc;
    logic                col_wrap;
    logic                row_wrap;
    logic                accept;

    logic                f_valid_reg;
    logic [CW-1:0]       f_col_reg;
    logic [PIX_W-1:0]    f_pixel_reg;
    logic                f_emit_reg;
    logic                f_last_reg;
    logic [LW-1:0]       rd_data_reg;

    logic [LW-1:0]       line_mem [MAX_WIDTH];

    // register writes are always taken at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(WIDTH_RESET);
            height_reg <= HEIGHT_W'(HEIGHT_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // effective frame size, saturated to the legal range
    always_comb begin
        w_ext = EW'(width_reg);
        if (w_ext < EW'(WIN)) begin
            eff_w = (CW + 1)'(WIN);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            eff_w = (CW + 1)'(MAX_WIDTH);
        end else begin
            eff_w = (CW + 1)'(w_ext);
        end
        if (height_reg < HEIGHT_W'(WIN)) begin
            eff_h = HEIGHT_W'(WIN);
        end else if (height_reg > HEIGHT_W'(MAX_HEIGHT)) begin
            eff_h = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            eff_h = height_reg;
        end
    end

    // position bookkeeping
    assign col_inc  = {1'b0, col_reg} + (CW + 1)'(1);
    assign row_inc  = {1'b0, row_reg} + (ROW_W + 1)'(1);
    assign col_wrap = col_inc >= eff_w;
    assign row_wrap = row_inc >= (ROW_W + 1)'(eff_h);

    // front stage frees up when its beat moves into the queue
    assign q_push  = f_valid_reg && !q_full;
    assign s_ready = !f_valid_reg || !q_full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            f_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                f_valid_reg <= 1'b1;
                if (col_wrap) begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    col_reg <= col_inc[CW-1:0];
                end
            end else if (q_push) begin
                f_valid_reg <= 1'b0;
            end
        end
    end

    // beat payload and class
    always_ff @(posedge aclk) begin
        if (accept) begin
            f_col_reg   <= col_reg;
            f_pixel_reg <= s_pixel;
            f_emit_reg  <= (row_reg >= ROW_W'(EDGE)) && (col_reg >= CW'(EDGE));
            f_last_reg  <= row_wrap && col_wrap;
        end
    end

    // line buffers: one word per column, newest line in the low byte
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (q_push) begin
            line_mem[f_col_reg] <= {rd_data_reg[LW-PIX_W-1:0], f_pixel_reg};
        end
    end

    always_comb begin
        q_data.lines = rd_data_reg;
        q_data.pixel = f_pixel_reg;
        q_data.emit  = f_emit_reg;
        q_data.last  = f_last_reg;
    end

endmodule

// File: sv/bbl_queue.sv
// ----------------------------------------------------------------------------
// bbl_queue
// Small first-in first-out queue of column records between front and back.
// ----------------------------------------------------------------------------
module bbl_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bbl_pkg::col_rec_t push_data,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop_ready,
    output bbl_pkg::col_rec_t pop_data
);
    import bbl_pkg::*;

    col_rec_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              pop;

    assign full      = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            priority if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W + 1)'(1);
            end else begin
                count_reg <= count_reg;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/bbl_back.sv
// ----------------------------------------------------------------------------
// bbl_back
// Sums each column, adds the newest column sum to the four before it for
// the 5x5 window sum and divides by 25 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module bbl_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  bbl_pkg::col_rec_t         q_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bbl_pkg::PIX_W-1:0] m_blurred,
    output logic                      m_last
);
    import bbl_pkg::*;

    logic                s1_valid_reg;
    logic [CSUM_W-1:0]   s1_csum_reg;
    logic                s1_emit_reg;
    logic                s1_last_reg;
    logic                s2_valid_reg;
    logic                s2_last_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;
    logic [CSUM_W-1:0]   csum_line_reg [LINES];
    logic                m_valid_reg;
    logic                m_last_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic [CSUM_W-1:0]   csum_next;
    logic                s1_ready;
    logic                s2_ready;
    logic                s3_ready;
    logic                adv12;

    // stall chain, each stage moves when the one after it has room
    assign s3_ready = !m_valid_reg || m_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign q_ready  = s1_ready;
    assign adv12    = s1_valid_reg && s2_ready;

    // column sum of the new pixel and the four buffered lines
    always_comb begin
        csum_next = CSUM_W'(q_data.pixel);
        for (int k = 0; k < LINES; k++) begin
            csum_next = csum_next + CSUM_W'(q_data.lines[k*PIX_W +: PIX_W]);
        end
    end

    // window sum: the new column plus the four before it
    always_comb begin
        total_next = TOTAL_W'(s1_csum_reg);
        for (int k = 0; k < LINES; k++) begin
            total_next = total_next + TOTAL_W'(csum_line_reg[k]);
        end
    end

    // stage 1: column sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && s1_ready) begin
            s1_csum_reg <= csum_next;
            s1_emit_reg <= q_data.emit;
            s1_last_reg <= q_data.last;
        end
    end

    // stage 2: window shift, only result beats go on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            total_reg    <= '0;
            for (int i = 0; i < LINES; i++) begin
                csum_line_reg[i] <= '0;
            end
        end else begin
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
            if (adv12) begin
                total_reg <= total_next;
                for (int i = 0; i < LINES - 1; i++) begin
                    csum_line_reg[i] <= csum_line_reg[i+1];
                end
                csum_line_reg[LINES-1] <= s1_csum_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv12) begin
            s2_last_reg <= s1_last_reg;
        end
    end

    // stage 3: reciprocal multiply into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s3_ready) begin
            prod_reg   <= PROD_W'(total_reg) * PROD_W'(RECIP);
            m_last_reg <= s2_last_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_last    = m_last_reg;
    assign m_blurred = prod_reg[RECIP_SHIFT +: PIX_W];

endmodule

// File: sv/box_blur_5x5_stream.sv
// Path: front register, queue, column sum stage, window sum stage, output register.
// One pixel per cycle unless stalled; each pixel takes one line buffer read and write.
// Reset clears the row and column counters, the window sums and all valid flags,
// and loads width and height with 512. The line buffers are not cleared; entries
// read before they are written only feed border pixels, which give no result.
// ----------------------------------------------------------------------------
// box_blur_5x5_stream
// 5x5 mean filter over a raster pixel stream, border of two pixels dropped.
// ----------------------------------------------------------------------------
module box_blur_5x5_stream #(
    parameter int MAX_WIDTH = bbl_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  bbl_pkg::cfg_index_t            cfg_index,
    input  logic [bbl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bbl_pkg::PIX_W-1:0]      s_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bbl_pkg::PIX_W-1:0]      m_blurred,
    output logic                           m_last
);
    import bbl_pkg::*;

    logic     q_push;
    logic     q_full;
    col_rec_t q_in;
    logic     q_valid;
    logic     q_ready;
    col_rec_t q_out;

    // position tracking and line buffers
    bbl_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_pixel  (s_pixel),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_data   (q_in)
    );

    // decoupling queue
    bbl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop_valid(q_valid),
        .pop_ready(q_ready),
        .pop_data (q_out)
    );

    // window sum and divide
    bbl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_out),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_blurred(m_blurred),
        .m_last   (m_last)
    );

endmodule

// File: sv/bbl_checker.sv
// ----------------------------------------------------------------------------
// bbl_checker
// Port-level checks on the box blur stream, bound to the top level.
// ----------------------------------------------------------------------------
module bbl_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [bbl_pkg::PIX_W-1:0] m_blurred,
    input logic                      m_last
);
    import bbl_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_blurred) && $stable(m_last))
        else $error("result beat changed while stalled");

    // downstream ready in the previous cycle drains the queue enough to take a pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_ready) |-> s_ready)
        else $error("input stalled although output was being drained");

    // no result can come out right after reset
    assert property (@(posedge aclk)
        !$past(aresetn) || !$past(aresetn, 2) |-> !m_valid)
        else $error("result beat too soon after reset");

endmodule

bind box_blur_5x5_stream bbl_checker u_checker (.*);
